>>> rtl/core/hsl_to_rgb_converter_top_defines.svh
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HSL2RGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HSL2RGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hsl2rgb_pkg.sv
// Shared constants and types for the HSL to RGB converter.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int HUE_BITS      = 16;
    localparam int HUE6_BITS     = HUE_BITS + 3;
    localparam int CH_BITS       = 8;
    localparam int STAGES        = 5;

    // Hue sextant; names give the channel at v and the one that ramps.
    typedef enum logic [2:0] {
        SX_R_G = 3'd0,
        SX_G_R = 3'd1,
        SX_G_B = 3'd2,
        SX_B_G = 3'd3,
        SX_B_R = 3'd4,
        SX_R_B = 3'd5
    } t_sextant;

    // Per-stage load enables.
    typedef struct packed {
        logic st5;
        logic st4;
        logic st3;
        logic st2;
        logic st1;
    } t_stage_en;

endpackage

>>> rtl/core/hsl2rgb_vm.sv
// Stages 1-2: clamp, l*s product, hue*6 split, then v, m and v-m.
`timescale 1ns / 1ps

module hsl2rgb_vm #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  hsl2rgb_pkg::t_stage_en              i_en,
    input  logic [hsl2rgb_pkg::HUE_BITS-1:0]    i_hue,
    input  logic [FRAC_BITS:0]                  i_saturation,
    input  logic [FRAC_BITS:0]                  i_lightness,
    output logic [2*FRAC_BITS:0]                o_v,
    output logic [2*FRAC_BITS:0]                o_m,
    output logic [2*FRAC_BITS:0]                o_d,
    output logic                                o_vzero,
    output hsl2rgb_pkg::t_sextant               o_sext,
    output logic [hsl2rgb_pkg::HUE_BITS-1:0]    o_frac,
    output logic [FRAC_BITS:0]                  o_light
);

    localparam int W   = 2 * FRAC_BITS + 1;
    localparam int H6W = hsl2rgb_pkg::HUE6_BITS;
    localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // stage 1
    logic [FRAC_BITS:0]                 n_s, n_l;
    logic [2*FRAC_BITS+1:0]             n_ls_full;
    logic [H6W-1:0]                     n_h6;
    logic [FRAC_BITS:0]                 r_s, r_l;
    logic [W-1:0]                       r_ls;
    logic                               r_low;
    hsl2rgb_pkg::t_sextant              r_sext;
    logic [hsl2rgb_pkg::HUE_BITS-1:0]   r_frac;

    // stage 2
    logic [W-1:0] n_lw, n_sc, n_t;
    logic [W-1:0] r_v, r_m, r_d;
    logic         r_vzero;
    hsl2rgb_pkg::t_sextant              r_sext2;
    logic [hsl2rgb_pkg::HUE_BITS-1:0]   r_frac2;
    logic [FRAC_BITS:0]                 r_l2;

    always_comb begin
        n_s       = (i_saturation > ONE) ? ONE : i_saturation;
        n_l       = (i_lightness > ONE) ? ONE : i_lightness;
        n_ls_full = (2*FRAC_BITS+2)'(n_s) * (2*FRAC_BITS+2)'(n_l);
        n_h6      = H6W'(i_hue) * H6W'(6);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st1) begin
            r_s    <= n_s;
            r_l    <= n_l;
            r_ls   <= n_ls_full[W-1:0];
            r_low  <= (n_l <= HALF);
            r_sext <= hsl2rgb_pkg::t_sextant'(n_h6[H6W-1:hsl2rgb_pkg::HUE_BITS]);
            r_frac <= n_h6[hsl2rgb_pkg::HUE_BITS-1:0];
        end
    end

    // v = l + t, m = l - t, with t = l*s at or below half lightness, else s*(1-l)
    always_comb begin
        n_lw = {r_l, {FRAC_BITS{1'b0}}};
        n_sc = {r_s, {FRAC_BITS{1'b0}}} - r_ls;
        n_t  = r_low ? r_ls : n_sc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st2) begin
            r_v     <= n_lw + n_t;
            r_m     <= n_lw - n_t;
            r_d     <= {n_t[W-2:0], 1'b0};
            r_vzero <= ((n_lw + n_t) == '0);
            r_sext2 <= r_sext;
            r_frac2 <= r_frac;
            r_l2    <= r_l;
        end
    end

    assign o_v     = r_v;
    assign o_m     = r_m;
    assign o_d     = r_d;
    assign o_vzero = r_vzero;
    assign o_sext  = r_sext2;
    assign o_frac  = r_frac2;
    assign o_light = r_l2;

endmodule

>>> rtl/core/hsl2rgb_ramp.sv
// Stages 3-4: ramp product (v-m)*f, then ramp values and sextant select.
`timescale 1ns / 1ps

module hsl2rgb_ramp #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  hsl2rgb_pkg::t_stage_en              i_en,
    input  logic [2*FRAC_BITS:0]                i_v,
    input  logic [2*FRAC_BITS:0]                i_m,
    input  logic [2*FRAC_BITS:0]                i_d,
    input  logic                                i_vzero,
    input  hsl2rgb_pkg::t_sextant               i_sext,
    input  logic [hsl2rgb_pkg::HUE_BITS-1:0]    i_frac,
    input  logic [FRAC_BITS:0]                  i_light,
    output logic [2*FRAC_BITS:0]                o_red,
    output logic [2*FRAC_BITS:0]                o_green,
    output logic [2*FRAC_BITS:0]                o_blue
);

    localparam int W  = 2 * FRAC_BITS + 1;
    localparam int PW = W + hsl2rgb_pkg::HUE_BITS;

    logic [PW-1:0]          n_prod;
    logic [W-1:0]           r_vsf, r_v, r_m;
    logic                   r_vzero;
    hsl2rgb_pkg::t_sextant  r_sext;
    logic [FRAC_BITS:0]     r_l;

    logic [W-1:0] n_mid1, n_mid2, n_red, n_grn, n_blu;
    logic [W-1:0] r_red, r_grn, r_blu;

    assign n_prod = PW'(i_d) * PW'(i_frac);

    always_ff @(posedge i_clk) begin
        if (i_en.st3) begin
            r_vsf   <= n_prod[PW-1:hsl2rgb_pkg::HUE_BITS];
            r_v     <= i_v;
            r_m     <= i_m;
            r_vzero <= i_vzero;
            r_sext  <= i_sext;
            r_l     <= i_light;
        end
    end

    always_comb begin
        n_mid1 = r_m + r_vsf;
        n_mid2 = r_v - r_vsf;
        unique case (r_sext)
            hsl2rgb_pkg::SX_R_G: begin
                n_red = r_v;    n_grn = n_mid1; n_blu = r_m;
            end
            hsl2rgb_pkg::SX_G_R: begin
                n_red = n_mid2; n_grn = r_v;    n_blu = r_m;
            end
            hsl2rgb_pkg::SX_G_B: begin
                n_red = r_m;    n_grn = r_v;    n_blu = n_mid1;
            end
            hsl2rgb_pkg::SX_B_G: begin
                n_red = r_m;    n_grn = n_mid2; n_blu = r_v;
            end
            hsl2rgb_pkg::SX_B_R: begin
                n_red = n_mid1; n_grn = r_m;    n_blu = r_v;
            end
            hsl2rgb_pkg::SX_R_B: begin
                n_red = r_v;    n_grn = r_m;    n_blu = n_mid2;
            end
            default: begin
                n_red = r_v;    n_grn = r_m;    n_blu = n_mid2;
            end
        endcase
        // gray when v is zero
        if (r_vzero) begin
            n_red = {r_l, {FRAC_BITS{1'b0}}};
            n_grn = {r_l, {FRAC_BITS{1'b0}}};
            n_blu = {r_l, {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st4) begin
            r_red <= n_red;
            r_grn <= n_grn;
            r_blu <= n_blu;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_grn;
    assign o_blue  = r_blu;

endmodule

>>> rtl/core/hsl2rgb_byte.sv
// Stage 5: scale each channel by 255 and keep the integer byte.
`timescale 1ns / 1ps

module hsl2rgb_byte #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  hsl2rgb_pkg::t_stage_en              i_en,
    input  logic [2*FRAC_BITS:0]                i_red,
    input  logic [2*FRAC_BITS:0]                i_green,
    input  logic [2*FRAC_BITS:0]                i_blue,
    output logic [hsl2rgb_pkg::CH_BITS-1:0]     o_red,
    output logic [hsl2rgb_pkg::CH_BITS-1:0]     o_green,
    output logic [hsl2rgb_pkg::CH_BITS-1:0]     o_blue
);

    localparam int W  = 2 * FRAC_BITS + 1;
    localparam int CB = hsl2rgb_pkg::CH_BITS;

    logic [CB-1:0] r_red, r_grn, r_blu;

    // x*255 as (x << 8) - x, then floor by dropping the fraction bits
    function automatic logic [CB-1:0] to_byte(input logic [W-1:0] x);
        logic [W+CB-1:0] scaled;
        scaled  = {x, {CB{1'b0}}} - {{CB{1'b0}}, x};
        return scaled[2*FRAC_BITS+CB-1:2*FRAC_BITS];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en.st5) begin
            r_red <= to_byte(i_red);
            r_grn <= to_byte(i_green);
            r_blu <= to_byte(i_blue);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_grn;
    assign o_blue  = r_blu;

endmodule

>>> rtl/core/hsl_to_rgb_converter_top.sv
// HSL to RGB converter top level: a five-stage pipeline that takes one
// hue/saturation/lightness beat per clock while o_stall is low and returns one
// 8-bit red/green/blue beat for each, in order. Throughput is one beat per clock
// when the output is not stalled; each beat passes the five register stages
// (operand product, v/m, ramp product, sextant select, byte scaling).
// Each stage holds only while it is full and the stage after it cannot load,
// so empty slots close up under an output stall and input keeps flowing until
// all five stages are full. Saturation and lightness carry FRAC_BITS fraction
// bits and are clamped to one; hue is a 16-bit fraction of a turn.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_top_defines.svh"

module hsl_to_rgb_converter_top #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hsl2rgb_pkg::HUE_BITS-1:0]    i_hue,
    input  logic [FRAC_BITS:0]                  i_saturation,
    input  logic [FRAC_BITS:0]                  i_lightness,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hsl2rgb_pkg::CH_BITS-1:0]     o_red,
    output logic [hsl2rgb_pkg::CH_BITS-1:0]     o_green,
    output logic [hsl2rgb_pkg::CH_BITS-1:0]     o_blue
);

    localparam int NS = hsl2rgb_pkg::STAGES;
    localparam int W  = 2 * FRAC_BITS + 1;

    logic [NS-1:0]          r_valid, n_valid, n_en;
    hsl2rgb_pkg::t_stage_en n_stage_en;

    logic [W-1:0]                       w_v, w_m, w_d;
    logic                               w_vzero;
    hsl2rgb_pkg::t_sextant              w_sext;
    logic [hsl2rgb_pkg::HUE_BITS-1:0]   w_frac;
    logic [FRAC_BITS:0]                 w_light;
    logic [W-1:0]                       w_red, w_grn, w_blu;

    // a stage loads when it is empty or the next stage loads
    always_comb begin
        n_en[NS-1] = !r_valid[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            n_en[k] = !r_valid[k] || n_en[k+1];
        end
        n_valid[0] = n_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < NS; k++) begin
            n_valid[k] = n_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    assign n_stage_en = hsl2rgb_pkg::t_stage_en'(n_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !n_en[0];
    assign o_valid = r_valid[NS-1];

    hsl2rgb_vm #(
        .FRAC_BITS(FRAC_BITS)
    ) u_vm (
        .i_clk       (i_clk),
        .i_en        (n_stage_en),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_lightness (i_lightness),
        .o_v         (w_v),
        .o_m         (w_m),
        .o_d         (w_d),
        .o_vzero     (w_vzero),
        .o_sext      (w_sext),
        .o_frac      (w_frac),
        .o_light     (w_light)
    );

    hsl2rgb_ramp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ramp (
        .i_clk  (i_clk),
        .i_en   (n_stage_en),
        .i_v    (w_v),
        .i_m    (w_m),
        .i_d    (w_d),
        .i_vzero(w_vzero),
        .i_sext (w_sext),
        .i_frac (w_frac),
        .i_light(w_light),
        .o_red  (w_red),
        .o_green(w_grn),
        .o_blue (w_blu)
    );

    hsl2rgb_byte #(
        .FRAC_BITS(FRAC_BITS)
    ) u_byte (
        .i_clk  (i_clk),
        .i_en   (n_stage_en),
        .i_red  (w_red),
        .i_green(w_grn),
        .i_blue (w_blu),
        .o_red  (o_red),
        .o_green(o_green),
        .o_blue (o_blue)
    );

    `HSL2RGB_ASSERT_IMP(a_empty_out_no_stall, i_clk, i_rst_n, !r_valid[NS-1], !o_stall, "input stalled with empty output stage")
    `HSL2RGB_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, (&r_valid) && i_stall, o_stall, "input taken while pipeline full and output stalled")
    `HSL2RGB_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_valid && !o_stall, r_valid[0], "accepted beat missing from first stage")

endmodule
